@@ rtl/twi_seq_pkg.sv @@
package twi_seq_pkg;

    // Transfer buffer geometry. Entry 0 holds the address byte.
    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int POS_W     = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W     = (POS_W > 6) ? POS_W : 6;

    // Configuration port.
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;
    localparam logic [13:0]          TIMEOUT_RESET     = 14'd10000;

    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_EVENT  = 3'd1,
        REQ_TICK   = 3'd2,
        REQ_BUF_WR = 3'd3,
        REQ_BUF_RD = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_BUSY    = 4'd1,
        ST_OK      = 4'd2,
        ST_EBUSY   = 4'd3,
        ST_ESTOP   = 4'd4,
        ST_ESTART  = 4'd5,
        ST_TIMEOUT = 4'd6,
        ST_ARB     = 4'd7,
        ST_NACK    = 4'd8,
        ST_UNEXP   = 4'd9
    } st_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_ABORT    = 3'd1,
        CMD_START    = 3'd2,
        CMD_CONT     = 3'd3,
        CMD_CONT_ACK = 3'd4,
        CMD_STOP     = 3'd5,
        CMD_RELEASE  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
        logic       stop_pending;
        logic       start_pending;
        logic [4:0] buf_index;
        logic [7:0] buf_data;
    } item_t;

    typedef struct packed {
        st_t        status;
        cmd_t       ctl_command;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_data;
        logic       accepted;
        logic [7:0] last_bus_status;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    typedef struct packed {
        logic                 wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } cfg_wr_t;

endpackage

@@ rtl/twi_seq_buf.sv @@
module twi_seq_buf (
    input  logic                      aclk,
    input  twi_seq_pkg::buf_wr_t      wr,
    input  logic [twi_seq_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import twi_seq_pkg::*;

    logic [7:0] mem_reg [BUF_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // Addresses past a non power of two depth read as zero.
    assign rd_data = ({1'b0, rd_addr} < (BUF_AW + 1)'(BUF_DEPTH)) ? mem_reg[rd_addr] : 8'h00;

endmodule

@@ rtl/twi_seq_core.sv @@
module twi_seq_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  twi_seq_pkg::cfg_wr_t           cfg,
    input  logic                           item_en,
    input  twi_seq_pkg::item_t             item,
    output twi_seq_pkg::result_t           res,
    output twi_seq_pkg::buf_wr_t           buf_wr,
    output logic [twi_seq_pkg::BUF_AW-1:0] buf_rd_addr,
    input  logic [7:0]                     buf_rd_data
);
    import twi_seq_pkg::*;

    // Bus engine status codes after masking the prescaler bits.
    localparam logic [7:0] TWS_MASK        = 8'hF8;
    localparam logic [7:0] TWS_BUS_ERROR   = 8'h00;
    localparam logic [7:0] TWS_START       = 8'h08;
    localparam logic [7:0] TWS_REP_START   = 8'h10;
    localparam logic [7:0] TWS_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] TWS_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] TWS_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] TWS_DATA_W_NACK = 8'h30;
    localparam logic [7:0] TWS_ARB_LOST    = 8'h38;
    localparam logic [7:0] TWS_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] TWS_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] TWS_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] TWS_DATA_R_NACK = 8'h58;

    st_t              run_status_reg, run_status_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic             irq_on_reg, irq_on_next;
    logic [13:0]      tick_count_reg, tick_count_next;
    logic [7:0]       latest_reg, latest_next;
    logic [5:0]       byte_count_reg;
    logic [13:0]      timeout_reg;

    logic [CMP_W-1:0] bc_ext;
    logic [CMP_W-1:0] cnt;
    logic [7:0]       st_masked;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_rx;
    logic             pos_room;
    logic             idx_ok;
    logic [13:0]      tick_inc;

    assign bc_ext   = CMP_W'(byte_count_reg);
    assign cnt      = (bc_ext > CMP_W'(BUF_DEPTH)) ? CMP_W'(BUF_DEPTH) : bc_ext;
    assign st_masked = item.bus_status & TWS_MASK;
    assign pos_room = position_reg < POS_W'(BUF_DEPTH);
    assign idx_ok   = CMP_W'(item.buf_index) < CMP_W'(BUF_DEPTH);
    assign tick_inc = tick_count_reg + 14'd1;
    assign pos_base = ((st_masked == TWS_START) || (st_masked == TWS_REP_START))
                      ? '0 : position_reg;

    always_comb begin
        run_status_next = run_status_reg;
        position_next   = position_reg;
        irq_on_next     = irq_on_reg;
        tick_count_next = tick_count_reg;
        latest_next     = latest_reg;
        pos_rx          = position_reg;
        buf_wr          = '0;
        buf_rd_addr     = BUF_AW'(item.buf_index);
        res             = '0;
        res.status      = ST_IDLE;
        res.ctl_command = CMD_NONE;

        case (item.req_type)
            REQ_START: begin
                if (run_status_reg == ST_BUSY) begin
                    run_status_next = ST_EBUSY;
                end else if (item.stop_pending) begin
                    run_status_next = ST_ESTOP;
                end else if (item.start_pending) begin
                    res.ctl_command = CMD_ABORT;
                    irq_on_next     = 1'b0;
                    run_status_next = ST_ESTART;
                end else begin
                    run_status_next = ST_BUSY;
                    res.ctl_command = CMD_START;
                    irq_on_next     = 1'b1;
                    tick_count_next = '0;
                    res.accepted    = 1'b1;
                end
            end
            REQ_EVENT: begin
                if (irq_on_reg) begin
                    latest_next = st_masked;
                    case (st_masked)
                        TWS_START, TWS_REP_START, TWS_SLA_W_ACK, TWS_DATA_W_ACK: begin
                            position_next = pos_base;
                            buf_rd_addr   = BUF_AW'(pos_base);
                            if (CMP_W'(pos_base) < cnt) begin
                                res.tx_valid    = 1'b1;
                                res.tx_byte     = buf_rd_data;
                                position_next   = pos_base + POS_W'(1);
                                res.ctl_command = CMD_CONT;
                            end else begin
                                run_status_next = ST_OK;
                                res.ctl_command = CMD_STOP;
                                irq_on_next     = 1'b0;
                            end
                        end
                        TWS_DATA_R_ACK, TWS_SLA_R_ACK: begin
                            if ((st_masked == TWS_DATA_R_ACK) && pos_room) begin
                                buf_wr.en   = 1'b1;
                                buf_wr.addr = BUF_AW'(position_reg);
                                buf_wr.data = item.rx_byte;
                                pos_rx      = position_reg + POS_W'(1);
                            end
                            position_next = pos_rx;
                            // The byte about to be received is the last one: no ack.
                            if ((CMP_W + 1)'(pos_rx) + (CMP_W + 1)'(1) == (CMP_W + 1)'(cnt)) begin
                                res.ctl_command = CMD_CONT;
                            end else begin
                                res.ctl_command = CMD_CONT_ACK;
                            end
                        end
                        TWS_DATA_R_NACK: begin
                            if (pos_room) begin
                                buf_wr.en   = 1'b1;
                                buf_wr.addr = BUF_AW'(position_reg);
                                buf_wr.data = item.rx_byte;
                            end
                            run_status_next = ST_OK;
                            res.ctl_command = CMD_STOP;
                            irq_on_next     = 1'b0;
                        end
                        TWS_ARB_LOST: begin
                            res.ctl_command = CMD_RELEASE;
                            run_status_next = ST_ARB;
                            irq_on_next     = 1'b0;
                        end
                        TWS_BUS_ERROR, TWS_SLA_W_NACK, TWS_SLA_R_NACK, TWS_DATA_W_NACK: begin
                            res.ctl_command = CMD_STOP;
                            run_status_next = ST_NACK;
                            irq_on_next     = 1'b0;
                        end
                        default: begin
                            res.ctl_command = CMD_RELEASE;
                            run_status_next = ST_UNEXP;
                            irq_on_next     = 1'b0;
                        end
                    endcase
                end
            end
            REQ_TICK: begin
                if (!irq_on_reg) begin
                    res.accepted = 1'b1;
                end else begin
                    tick_count_next = tick_inc;
                    // A wrapped counter also ends the wait, and a zero limit acts as one tick.
                    if ((tick_inc >= timeout_reg) || (tick_inc == '0)) begin
                        res.ctl_command = CMD_ABORT;
                        irq_on_next     = 1'b0;
                        tick_count_next = '0;
                        if (run_status_reg < ST_EBUSY) begin
                            run_status_next = ST_TIMEOUT;
                        end
                    end
                end
            end
            REQ_BUF_WR: begin
                if (idx_ok) begin
                    buf_wr.en   = 1'b1;
                    buf_wr.addr = BUF_AW'(item.buf_index);
                    buf_wr.data = item.buf_data;
                end
            end
            REQ_BUF_RD: begin
                if (idx_ok) begin
                    res.read_data = buf_rd_data;
                end
            end
            default: begin
            end
        endcase

        res.status          = run_status_next;
        res.last_bus_status = latest_next;
        if (!item_en) begin
            buf_wr.en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_status_reg <= ST_IDLE;
            position_reg   <= '0;
            irq_on_reg     <= 1'b0;
            tick_count_reg <= '0;
            latest_reg     <= '0;
            byte_count_reg <= '0;
            timeout_reg    <= TIMEOUT_RESET;
        end else begin
            if (item_en) begin
                run_status_reg <= run_status_next;
                position_reg   <= position_next;
                irq_on_reg     <= irq_on_next;
                tick_count_reg <= tick_count_next;
                latest_reg     <= latest_next;
            end
            if (cfg.wr_en) begin
                case (cfg.index)
                    REG_BYTE_COUNT:    byte_count_reg <= cfg.data[5:0];
                    REG_TIMEOUT_TICKS: timeout_reg    <= cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/twi_master_transfer_sequencer_top.sv @@
// I2C master transfer sequencer.
// The input channel (s_valid/s_ready) carries one request per beat: a start
// request, a bus status event with its received byte, a timeout tick, or a
// transfer buffer write or read. The result channel (m_valid/m_ready) returns
// exactly one beat per request with the transfer status, the command for the
// byte-level bus engine, an optional byte to transmit, buffer read data and
// the latest masked bus status.
// Each beat is captured in an input register, decoded against the sequencer
// state and the buffer, and lands in an output register. One request is
// taken per cycle for as long as results are drained; each decode does at
// most one buffer read or write.
// When the receiver stalls, the result is held in the output register and the
// input register keeps the next request; further input waits only once both
// are full. The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes
// the byte count and timeout tick limit and must be used only while no
// request is in flight.
// A synchronous low aresetn empties both registers, returns the sequencer to
// idle with interrupts off, and restores the configuration defaults. The
// buffer contents are not cleared and must be written before they are read.
module twi_master_transfer_sequencer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [twi_seq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [twi_seq_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_req_type,
    input  logic [7:0]                        s_bus_status,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_stop_pending,
    input  logic                              s_start_pending,
    input  logic [4:0]                        s_buf_index,
    input  logic [7:0]                        s_buf_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [3:0]                        m_status,
    output logic [2:0]                        m_ctl_command,
    output logic                              m_tx_valid,
    output logic [7:0]                        m_tx_byte,
    output logic [7:0]                        m_read_data,
    output logic                              m_accepted,
    output logic [7:0]                        m_last_bus_status
);
    import twi_seq_pkg::*;

    logic              in_valid_reg;
    item_t             item_reg;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    logic              advance;
    cfg_wr_t           cfg;
    buf_wr_t           buf_wr;
    logic [BUF_AW-1:0] buf_rd_addr;
    logic [7:0]        buf_rd_data;

    // The held request moves on whenever the output register is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.req_type      <= s_req_type;
            item_reg.bus_status    <= s_bus_status;
            item_reg.rx_byte       <= s_rx_byte;
            item_reg.stop_pending  <= s_stop_pending;
            item_reg.start_pending <= s_start_pending;
            item_reg.buf_index     <= s_buf_index;
            item_reg.buf_data      <= s_buf_data;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    twi_seq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_en     (advance),
        .item        (item_reg),
        .res         (res_next),
        .buf_wr      (buf_wr),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data)
    );

    twi_seq_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    assign m_valid           = out_valid_reg;
    assign m_status          = res_reg.status;
    assign m_ctl_command     = res_reg.ctl_command;
    assign m_tx_valid        = res_reg.tx_valid;
    assign m_tx_byte         = res_reg.tx_byte;
    assign m_read_data       = res_reg.read_data;
    assign m_accepted        = res_reg.accepted;
    assign m_last_bus_status = res_reg.last_bus_status;

endmodule

@@ rtl/twi_seq_checker.sv @@
module twi_seq_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_status,
    input logic [2:0] m_ctl_command,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic       m_accepted
);
    import twi_seq_pkg::*;

    // A stalled result keeps its fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_ctl_command))
        else $error("stalled result changed");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A byte to send always goes with a plain continue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid |-> m_ctl_command == CMD_CONT)
        else $error("tx byte without continue command");

    // No byte is shown unless it is to be sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_byte == 8'h00)
        else $error("tx byte nonzero without tx valid");

    // Accepted is a started transfer or an idle tick, nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |->
            (m_ctl_command == CMD_START && m_status == ST_BUSY) ||
            (m_ctl_command == CMD_NONE))
        else $error("accepted flag with wrong command");

endmodule

bind twi_master_transfer_sequencer_top twi_seq_checker u_twi_seq_checker (.*);
